### hdl/csa_pkg.sv
// shared types and constants for the contiguous slot allocator
package csa_pkg;

  // transaction field widths
  localparam int unsigned MODE_W    = 1;
  localparam int unsigned START_W   = 12;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned SPARE_W   = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 12;
  localparam int unsigned PAGES_W   = 3;
  localparam int unsigned RESV_W    = 13;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // rounded growth value width
  localparam int unsigned NEED_W = 14;

  localparam logic [MODE_W-1:0] MODE_RESERVE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REL  = 2'd2;

  localparam logic [RESV_W-1:0] RESV_RESET = 13'd4096;

  typedef enum logic [4:0] {
    S_IDLE,
    S_REL_CHK,
    S_FIT_INIT,
    S_ADV,
    S_RD0,
    S_RD1,
    S_DISP,
    S_SPLIT0,
    S_SPLIT1,
    S_SPLIT2,
    S_REL_W0,
    S_REL_W1,
    S_REL_W2,
    S_REL_M0,
    S_REL_M1,
    S_GROW0,
    S_GROW1,
    S_GROW2,
    S_GROW3,
    S_GROW4,
    S_FINISH
  } state_e;

endpackage

### hdl/csa_store.sv
// slot store: single-port-write, registered-read memory
module csa_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 14
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/contiguous_slot_allocator.sv
// top level of the contiguous slot allocator
//
// usage
//   s_axis carries one request transaction: reserve or release a run of
//   contiguous slots. m_axis returns one result transaction per request:
//   status, first reserved slot and pages committed while serving it.
//   cfg_we_i/cfg_wdata_i write reserved_end, only while the block is idle.
// sequencing
//   one request at a time. each free-list node visited takes an advance, a
//   first-entry read, a length read and a decision, bounded by the one read
//   port of the slot store. a reserve adds split writes, growth-check steps
//   and, per growth step, a release walk; a release writes the run head,
//   its length, the predecessor link and, on a merge, the predecessor run.
// reset
//   free list empty, committed region empty, reserved_end 4096. the store
//   itself is not cleared: no entry is read before it is written.
// stall
//   a finished result sits in the output register; a new request is taken
//   while it waits. if the next result is ready before the old one is taken,
//   the block holds in its finish step until m_axis_tready.
module contiguous_slot_allocator
  import csa_pkg::*;
#(
  parameter int unsigned SLOTS      = 4096,
  parameter int unsigned PAGE_SLOTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request: mode[0], start_slot[12:1], count[25:13], pages_available[41:26]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // result: status[1:0], slot[13:2], pages_committed[16:14]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // reserved_end register
  input  logic                  cfg_we_i,
  input  logic [RESV_W-1:0]     cfg_wdata_i
);

  // index, pointer (index or end marker), entry and arithmetic widths
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned PTR_W = $clog2(SLOTS + 1);
  localparam int unsigned EW    = PTR_W + 1;
  localparam int unsigned VW    = ((PTR_W > NEED_W) ? PTR_W : NEED_W) + 1;
  // ceiling division by page size via reciprocal multiply
  localparam int unsigned SH    = 27;
  localparam int unsigned RW    = SH + 1;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / PAGE_SLOTS
                                        + ((((64'd1 << SH) % PAGE_SLOTS) != 0) ? 1 : 0));
  localparam int unsigned PW    = RW + NEED_W;

  localparam logic [VW-1:0] SLOTS_V = VW'(SLOTS);
  localparam logic [PTR_W-1:0] NIL  = PTR_W'(SLOTS);

  state_e state_q, state_d;

  // architectural state
  logic [RESV_W-1:0] resv_end_q;
  logic [PTR_W-1:0]  free_head_q, free_head_d;
  logic [PTR_W-1:0]  ce_q, ce_d;

  // walk registers
  logic              prev_head_q, prev_head_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  logic              prev_flag_q, prev_flag_d;
  logic [PTR_W-1:0]  prev_sz_q, prev_sz_d;
  logic [PTR_W-1:0]  plink_q, plink_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic              cflag_q, cflag_d;
  logic [PTR_W-1:0]  clink_q, clink_d;
  logic [PTR_W-1:0]  csz_q, csz_d;

  // request registers
  logic [COUNT_W-1:0] req_n_q, req_n_d;
  logic [VW-1:0]      rn_q, rn_d;
  logic [IDX_W-1:0]   rstart_q, rstart_d;
  logic [VW-1:0]      rem_q, rem_d;
  logic [PTR_W-1:0]   extra_q, extra_d;
  logic [SPARE_W-1:0] spare_q, spare_d;
  logic [PAGES_W-1:0] pages_q, pages_d;
  logic [NEED_W-1:0]  x_q, x_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic [NEED_W-1:0]  pg_q, pg_d;
  logic [NEED_W-1:0]  need_q, need_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic               grow_q, grow_d;
  logic               rel_op_q, rel_op_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // slot store port
  logic              mem_we_req;
  logic              mem_we;
  logic [VW-1:0]     mem_wa_v;
  logic [EW-1:0]     mem_wd;
  logic [VW-1:0]     mem_ra_v;
  logic [EW-1:0]     mem_rdata;

  // request fields
  logic [MODE_W-1:0]  in_mode;
  logic [START_W-1:0] in_start;
  logic [COUNT_W-1:0] in_count;
  logic [SPARE_W-1:0] in_spare;

  assign in_mode  = s_axis_tdata[0];
  assign in_start = s_axis_tdata[12:1];
  assign in_count = s_axis_tdata[25:13];
  assign in_spare = s_axis_tdata[41:26];

  // decision terms
  logic          in_fire, out_free;
  logic          adv_nil;
  logic [VW-1:0] cur_v, prev_v, rstart_v, req_n_v, csz_v, rel_end_v, limit_v, ce_v;
  logic          fit_exact, fit_split;
  logic          rel_after, rel_overlap, rel_adjacent, rel_hits_prev;
  logic          rel_skip, merge_prev, grow_fail;
  logic [PAGES_W-1:0] out_pages;
  state_e        rel_done_st;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign cur_v     = VW'(cur_q);
  assign prev_v    = VW'(prev_q);
  assign rstart_v  = VW'(rstart_q);
  assign req_n_v   = VW'(req_n_q);
  assign csz_v     = VW'(csz_q);
  assign ce_v      = VW'(ce_q);
  assign rel_end_v = rstart_v + rn_q;
  assign limit_v   = (VW'(resv_end_q) < SLOTS_V) ? VW'(resv_end_q) : SLOTS_V;

  // list end, or a link that does not move forward
  assign adv_nil = (VW'(plink_q) >= SLOTS_V)
                || (!prev_head_q && (VW'(plink_q) <= prev_v));

  assign fit_exact = (csz_v == req_n_v);
  assign fit_split = !cflag_q && (csz_v > req_n_v);

  assign rel_after     = (cur_v > rstart_v);
  assign rel_overlap   = rel_after && (cur_v < rel_end_v);
  assign rel_adjacent  = (cur_v == rel_end_v);
  assign rel_hits_prev = !rel_after && ((cur_v + csz_v) > rstart_v);

  assign rel_skip   = (rn_q == '0) || (rel_end_v > ce_v);
  assign merge_prev = !prev_head_q && ((prev_v + VW'(prev_sz_q)) == rstart_v);
  assign grow_fail  = (need_q == '0) || (limit_v <= ce_v)
                   || ((limit_v - ce_v) <= VW'(need_q))
                   || (spare_q < SPARE_W'(pg_q));

  // a release reports no committed pages
  assign out_pages = (status_q == STATUS_REL) ? {PAGES_W{1'b0}} : pages_q;

  assign rel_done_st = grow_q ? S_FIT_INIT : S_FINISH;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_RELEASE) begin
            state_d = S_REL_CHK;
          end else if (in_count == '0) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_FIT_INIT;
          end
        end
      end
      S_REL_CHK:  state_d = rel_skip ? rel_done_st : S_ADV;
      S_FIT_INIT: state_d = S_ADV;
      S_ADV: begin
        if (adv_nil) begin
          state_d = rel_op_q ? S_REL_W0 : S_GROW0;
        end else begin
          state_d = S_RD0;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_DISP;
      S_DISP: begin
        if (rel_op_q) begin
          if (rel_overlap || rel_hits_prev) begin
            state_d = rel_done_st;
          end else if (rel_after) begin
            state_d = S_REL_W0;
          end else begin
            state_d = S_ADV;
          end
        end else if (fit_exact) begin
          state_d = S_FINISH;
        end else if (fit_split) begin
          state_d = S_SPLIT0;
        end else begin
          state_d = S_ADV;
        end
      end
      S_SPLIT0: state_d = (extra_q > PTR_W'(1)) ? S_SPLIT1 : S_SPLIT2;
      S_SPLIT1: state_d = S_SPLIT2;
      S_SPLIT2: state_d = S_FINISH;
      S_REL_W0: state_d = (rn_q > VW'(1)) ? S_REL_W1 : S_REL_W2;
      S_REL_W1: state_d = S_REL_W2;
      S_REL_W2: state_d = merge_prev ? S_REL_M0 : rel_done_st;
      S_REL_M0: state_d = S_REL_M1;
      S_REL_M1: state_d = rel_done_st;
      S_GROW0:  state_d = S_GROW1;
      S_GROW1:  state_d = S_GROW2;
      S_GROW2:  state_d = S_GROW3;
      S_GROW3:  state_d = S_GROW4;
      S_GROW4:  state_d = grow_fail ? S_FINISH : S_REL_CHK;
      S_FINISH: state_d = out_free ? S_IDLE : S_FINISH;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and store accesses
  always_comb begin
    free_head_d = free_head_q;
    ce_d        = ce_q;
    prev_head_d = prev_head_q;
    prev_d      = prev_q;
    prev_flag_d = prev_flag_q;
    prev_sz_d   = prev_sz_q;
    plink_d     = plink_q;
    cur_d       = cur_q;
    cflag_d     = cflag_q;
    clink_d     = clink_q;
    csz_d       = csz_q;
    req_n_d     = req_n_q;
    rn_d        = rn_q;
    rstart_d    = rstart_q;
    rem_d       = rem_q;
    extra_d     = extra_q;
    spare_d     = spare_q;
    pages_d     = pages_q;
    x_d         = x_q;
    prod_d      = prod_q;
    pg_d        = pg_q;
    need_d      = need_q;
    status_d    = status_q;
    slot_d      = slot_q;
    grow_d      = grow_q;
    rel_op_d    = rel_op_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we_req  = 1'b0;
    mem_wa_v    = prev_v;
    mem_wd      = {prev_flag_q, plink_q};
    mem_ra_v    = VW'(plink_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          rstart_d = IDX_W'(in_start);
          rn_d     = VW'(in_count);
          req_n_d  = in_count;
          spare_d  = in_spare;
          pages_d  = '0;
          slot_d   = '0;
          grow_d   = 1'b0;
          if (in_mode == MODE_RELEASE) begin
            status_d = STATUS_REL;
            rel_op_d = 1'b1;
          end else begin
            status_d = STATUS_FAIL;
          end
        end
      end
      S_REL_CHK: begin
        rel_op_d    = 1'b1;
        prev_head_d = 1'b1;
        plink_d     = free_head_q;
      end
      S_FIT_INIT: begin
        rel_op_d    = 1'b0;
        grow_d      = 1'b0;
        prev_head_d = 1'b1;
        plink_d     = free_head_q;
      end
      S_ADV: begin
        mem_ra_v = VW'(plink_q);
        cur_d    = IDX_W'(plink_q);
      end
      S_RD0: begin
        cflag_d  = mem_rdata[EW-1];
        clink_d  = mem_rdata[PTR_W-1:0];
        mem_ra_v = cur_v + VW'(1);
      end
      S_RD1: begin
        if (cflag_q) begin
          csz_d = PTR_W'(1);
        end else if ((cur_v + VW'(1)) < SLOTS_V) begin
          csz_d = mem_rdata[PTR_W-1:0];
        end else begin
          csz_d = '0;
        end
      end
      S_DISP: begin
        if (rel_op_q) begin
          if (rel_after && !rel_overlap && rel_adjacent) begin
            // absorb the following run and unlink it
            rn_d    = rn_q + csz_v;
            plink_d = clink_q;
            if (prev_head_q) begin
              free_head_d = clink_q;
            end else begin
              mem_we_req = 1'b1;
              mem_wa_v   = prev_v;
              mem_wd     = {prev_flag_q, clink_q};
            end
          end else if (!rel_after && !rel_hits_prev) begin
            prev_head_d = 1'b0;
            prev_d      = cur_q;
            prev_flag_d = cflag_q;
            prev_sz_d   = csz_q;
            plink_d     = clink_q;
          end
        end else if (fit_exact) begin
          status_d = STATUS_OK;
          slot_d   = cur_q;
          if (prev_head_q) begin
            free_head_d = clink_q;
          end else begin
            mem_we_req = 1'b1;
            mem_wa_v   = prev_v;
            mem_wd     = {prev_flag_q, clink_q};
          end
        end else if (fit_split) begin
          extra_d = PTR_W'(csz_v - req_n_v);
          rem_d   = cur_v + req_n_v;
        end else begin
          prev_head_d = 1'b0;
          prev_d      = cur_q;
          prev_flag_d = cflag_q;
          prev_sz_d   = csz_q;
          plink_d     = clink_q;
        end
      end
      S_SPLIT0: begin
        // remainder head keeps the old link
        mem_we_req = 1'b1;
        mem_wa_v   = rem_q;
        mem_wd     = {(extra_q <= PTR_W'(1)), clink_q};
      end
      S_SPLIT1: begin
        mem_we_req = 1'b1;
        mem_wa_v   = rem_q + VW'(1);
        mem_wd     = {1'b0, extra_q};
      end
      S_SPLIT2: begin
        status_d = STATUS_OK;
        slot_d   = cur_q;
        if (prev_head_q) begin
          free_head_d = PTR_W'(rem_q);
        end else begin
          mem_we_req = 1'b1;
          mem_wa_v   = prev_v;
          mem_wd     = {prev_flag_q, PTR_W'(rem_q)};
        end
      end
      S_REL_W0: begin
        mem_we_req = 1'b1;
        mem_wa_v   = rstart_v;
        mem_wd     = {(rn_q <= VW'(1)), plink_q};
      end
      S_REL_W1: begin
        mem_we_req = 1'b1;
        mem_wa_v   = rstart_v + VW'(1);
        mem_wd     = {1'b0, PTR_W'(rn_q)};
      end
      S_REL_W2: begin
        if (prev_head_q) begin
          free_head_d = PTR_W'(rstart_q);
        end else begin
          mem_we_req = 1'b1;
          mem_wa_v   = prev_v;
          mem_wd     = {prev_flag_q, PTR_W'(rstart_q)};
        end
      end
      S_REL_M0: begin
        // previous run swallows the released one
        mem_we_req = 1'b1;
        mem_wa_v   = prev_v;
        mem_wd     = {1'b0, plink_q};
      end
      S_REL_M1: begin
        mem_we_req = 1'b1;
        mem_wa_v   = prev_v + VW'(1);
        mem_wd     = {1'b0, PTR_W'(rn_q + VW'(prev_sz_q))};
      end
      S_GROW0: begin
        slot_d = '0;
        if (!prev_head_q && ((prev_v + VW'(prev_sz_q)) == ce_v)
            && (VW'(prev_sz_q) < req_n_v)) begin
          x_d = NEED_W'(req_n_v - VW'(prev_sz_q)) + NEED_W'(PAGE_SLOTS - 1);
        end else begin
          x_d = NEED_W'(req_n_q) + NEED_W'(PAGE_SLOTS - 1);
        end
      end
      S_GROW1: prod_d = PW'(x_q) * PW'(RECIP);
      S_GROW2: pg_d   = NEED_W'(prod_q >> SH);
      S_GROW3: need_d = NEED_W'(pg_q * NEED_W'(PAGE_SLOTS));
      S_GROW4: begin
        if (!grow_fail) begin
          rstart_d = IDX_W'(ce_q);
          rn_d     = VW'(need_q);
          ce_d     = PTR_W'(ce_v + VW'(need_q));
          pages_d  = pages_q + pg_q[PAGES_W-1:0];
          spare_d  = spare_q - SPARE_W'(pg_q);
          grow_d   = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_DATA_W'({out_pages, SLOT_W'(slot_q), status_q});
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we = mem_we_req && (mem_wa_v < SLOTS_V);

  csa_store #(
    .DEPTH (SLOTS),
    .AW    (IDX_W),
    .DW    (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (IDX_W'(mem_wa_v)),
    .wdata_i (mem_wd),
    .raddr_i (IDX_W'(mem_ra_v)),
    .rdata_o (mem_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      resv_end_q  <= RESV_RESET;
      free_head_q <= NIL;
      ce_q        <= '0;
      out_valid_q <= 1'b0;
      grow_q      <= 1'b0;
      rel_op_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      ce_q        <= ce_d;
      out_valid_q <= out_valid_d;
      grow_q      <= grow_d;
      rel_op_q    <= rel_op_d;
      if (cfg_we_i) begin
        resv_end_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prev_head_q <= prev_head_d;
    prev_q      <= prev_d;
    prev_flag_q <= prev_flag_d;
    prev_sz_q   <= prev_sz_d;
    plink_q     <= plink_d;
    cur_q       <= cur_d;
    cflag_q     <= cflag_d;
    clink_q     <= clink_d;
    csz_q       <= csz_d;
    req_n_q     <= req_n_d;
    rn_q        <= rn_d;
    rstart_q    <= rstart_d;
    rem_q       <= rem_d;
    extra_q     <= extra_d;
    spare_q     <= spare_d;
    pages_q     <= pages_d;
    x_q         <= x_d;
    prod_q      <= prod_d;
    pg_q        <= pg_d;
    need_q      <= need_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    out_data_q  <= out_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // committed region only grows
  a_ce_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (ce_q >= $past(ce_q)))
    else $error("committed end moved back");

  // committed region never passes the slot range
  a_ce_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    VW'(ce_q) <= SLOTS_V)
    else $error("committed end beyond slot range");

  // the store is only written while a request is in progress
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE && state_q != S_FINISH))
    else $error("store write outside a request");
`endif

endmodule

### dv/contiguous_slot_allocator_tb.sv
// testbench for the contiguous slot allocator: directed corners and random traffic checked against a built-in predictor
module contiguous_slot_allocator_tb;
  import csa_pkg::*;

  localparam int unsigned NSLOT = 4096;
  localparam int unsigned PAGE  = 1024;
  localparam int unsigned LINK_M = 32'hFFFFF;
  localparam int unsigned ONE_F  = 32'h100000;
  localparam int unsigned HEAD_P = 32'hFFFFFFFF;
  localparam int unsigned CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
    logic [SPARE_W-1:0] spare;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PAGES_W-1:0]  pages;
    logic [COUNT_W-1:0]  count;
  } res_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } run_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [RESV_W-1:0] cfg_wdata_i = '0;

  contiguous_slot_allocator u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow allocator state
  int unsigned lim_reg = 4096;
  int unsigned head_q = NSLOT;
  int unsigned commit_end = 0;
  int unsigned store_mem [NSLOT];

  req_t req_q[$];
  res_t result_q[$];
  run_t live_q[$];
  req_t cur_req;
  bit idle_en = 1'b1;
  int unsigned long_hold = 0;
  int unsigned errors = 0;
  int unsigned n_done = 0, n_grow = 0, n_fail = 0;
  int unsigned cycles = 0;

  function automatic int unsigned rd_m(int unsigned i);
    return (i < NSLOT) ? store_mem[i] : 0;
  endfunction

  function automatic void wr_m(int unsigned i, int unsigned v);
    if (i < NSLOT) store_mem[i] = v;
  endfunction

  function automatic int unsigned link_at(int unsigned p);
    return (p == HEAD_P) ? head_q : (rd_m(p) & LINK_M);
  endfunction

  function automatic void set_link_at(int unsigned p, int unsigned nx);
    if (p == HEAD_P) head_q = nx;
    else wr_m(p, (rd_m(p) & ONE_F) | (nx & LINK_M));
  endfunction

  function automatic int unsigned len_at(int unsigned b);
    return (rd_m(b) & ONE_F) ? 1 : (rd_m(b + 1) & LINK_M);
  endfunction

  function automatic int unsigned next_run(int unsigned prv);
    int unsigned c;
    c = link_at(prv);
    if (c >= NSLOT) return NSLOT;
    if (prv != HEAD_P && c <= prv) return NSLOT;
    return c;
  endfunction

  function automatic void free_run(int unsigned st, int unsigned n);
    int unsigned prv, cur, psz;
    prv = HEAD_P;
    if (n == 0 || st + n > commit_end) return;
    for (cur = next_run(prv); cur != NSLOT; cur = next_run(prv)) begin
      if (cur > st) begin
        if (cur < st + n) return;
        // merge with the following free run
        if (cur == st + n) begin
          n += len_at(cur);
          set_link_at(prv, link_at(cur));
        end
        break;
      end
      if (cur + len_at(cur) > st) return;
      prv = cur;
    end
    if (n > 1) begin
      wr_m(st, link_at(prv) & LINK_M);
      wr_m(st + 1, n & LINK_M);
    end else begin
      wr_m(st, ONE_F | (link_at(prv) & LINK_M));
    end
    set_link_at(prv, st);
    // merge with the preceding free run
    if (prv != HEAD_P) begin
      psz = len_at(prv);
      if (prv + psz == st) begin
        wr_m(prv, rd_m(st) & LINK_M);
        wr_m(prv + 1, (n + psz) & LINK_M);
      end
    end
  endfunction

  function automatic bit first_fit(int unsigned n, output int unsigned slot,
                                   output int unsigned tail);
    int unsigned prv, cur, sz, rem, extra, nx;
    prv = HEAD_P;
    slot = 0;
    for (cur = next_run(prv); cur != NSLOT; cur = next_run(prv)) begin
      sz = len_at(cur);
      nx = link_at(cur);
      if (sz == n) begin
        set_link_at(prv, nx);
        slot = cur;
        return 1'b1;
      end
      if (!(rd_m(cur) & ONE_F) && sz > n) begin
        extra = sz - n;
        rem = cur + n;
        if (extra > 1) begin
          wr_m(rem, nx & LINK_M);
          wr_m(rem + 1, extra & LINK_M);
        end else begin
          wr_m(rem, ONE_F | (nx & LINK_M));
        end
        set_link_at(prv, rem);
        slot = cur;
        return 1'b1;
      end
      prv = cur;
    end
    tail = prv;
    return 1'b0;
  endfunction

  function automatic res_t serve_request(req_t r);
    res_t o;
    int unsigned n, spare, lim, tail, need, bsz, pg, slot, pages, old_end;
    n = r.count;
    spare = r.spare;
    o = '0;
    o.count = r.count;
    o.status = STATUS_REL;
    pages = 0;
    slot = 0;
    if (r.mode == MODE_RELEASE) begin
      free_run(r.start, n);
    end else if (n == 0) begin
      o.status = STATUS_FAIL;
    end else begin
      lim = (lim_reg < NSLOT) ? lim_reg : NSLOT;
      o.status = STATUS_FAIL;
      forever begin
        if (first_fit(n, slot, tail)) begin
          o.status = STATUS_OK;
          break;
        end
        slot = 0;
        need = n;
        if (tail != HEAD_P) begin
          bsz = len_at(tail);
          if (tail + bsz == commit_end && bsz < need) need -= bsz;
        end
        need = ((need + PAGE - 1) / PAGE) * PAGE;
        pg = need / PAGE;
        if (need == 0 || lim <= commit_end || lim - commit_end <= need || spare < pg) break;
        old_end = commit_end;
        commit_end += need;
        pages += pg;
        spare -= pg;
        free_run(old_end, need);
      end
    end
    o.slot = slot[SLOT_W-1:0];
    o.pages = pages[PAGES_W-1:0];
    return o;
  endfunction

  // sender: feeds queued requests, predicts each accepted transaction
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin : driver
    bit fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (fire) result_q.push_back(serve_request(cur_req));
      if (!s_axis_tvalid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_axis_tdata <= {6'b0, cur_req.spare, cur_req.count, cur_req.start, cur_req.mode};
          s_axis_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure, long hold on request, result check
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin : monitor
    res_t want;
    logic [STATUS_W-1:0] got_st;
    logic [SLOT_W-1:0] got_slot;
    logic [PAGES_W-1:0] got_pg;
    got_st = m_axis_tdata[1:0];
    got_slot = m_axis_tdata[13:2];
    got_pg = m_axis_tdata[16:14];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d pages=%0d",
                 $time, got_st, got_slot, got_pg);
        errors++;
      end else begin
        want = result_q.pop_front();
        n_done++;
        if (want.pages != 0) n_grow++;
        if (want.status == STATUS_FAIL) n_fail++;
        if (got_st !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got_st);
          errors++;
        end
        if (got_slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, got_slot);
          errors++;
        end
        if (got_pg !== want.pages) begin
          $display("%0t: pages expected %0d actual %0d", $time, want.pages, got_pg);
          errors++;
        end
        if (want.status == STATUS_OK) live_q.push_back({want.slot, want.count});
      end
    end
    if (rst_ni) begin
      if (long_hold > 0) begin
        long_hold--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_req(bit md, int unsigned st, int unsigned cnt, int unsigned sp);
    req_t r;
    r.mode = md;
    r.start = st[START_W-1:0];
    r.count = cnt[COUNT_W-1:0];
    r.spare = sp[SPARE_W-1:0];
    req_q.push_back(r);
  endtask

  // mostly reserves and releases of live runs, some partial releases and junk requests
  task automatic push_random(int unsigned n);
    int unsigned k, sel, idx, sp, cnt;
    run_t rn;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      sp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
      if (sel < 50) begin
        case ($urandom_range(0, 9))
          0: cnt = $urandom_range(1, 8191);
          1, 2: cnt = $urandom_range(65, 1500);
          default: cnt = $urandom_range(1, 64);
        endcase
        push_req(MODE_RESERVE, $urandom_range(0, 4095), cnt, sp);
      end else if (sel < 88 && live_q.size() > 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        rn = live_q[idx];
        live_q.delete(idx);
        if ($urandom_range(0, 4) == 0 && rn.count > 1)
          push_req(MODE_RELEASE, rn.start + 1, rn.count - 1, sp);
        else
          push_req(MODE_RELEASE, rn.start, rn.count, sp);
      end else begin
        push_req($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 8191), sp);
      end
    end
  endtask

  task automatic wait_idle();
    while (req_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[RESV_W-1:0];
    lim_reg = v & 32'h1FFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned lims [5] = '{0, 1500, 8191, 2049, 4096};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_limit(4096);

    // directed corners
    push_req(MODE_RESERVE, 0, 0, 65535);        // zero-length reserve
    push_req(MODE_RELEASE, 0, 0, 0);            // zero-length release
    push_req(MODE_RELEASE, 4095, 1, 0);         // release past committed end
    push_req(MODE_RESERVE, 0, 1, 0);            // no spare pages
    push_req(MODE_RESERVE, 4095, 8191, 65535);  // far too large
    push_req(MODE_RESERVE, 0, 1, 65535);        // first growth
    push_req(MODE_RESERVE, 0, 1023, 1);         // exact fit of the rest
    push_req(MODE_RESERVE, 0, 4096, 65535);     // limit not strictly above
    push_req(MODE_RESERVE, 0, 1500, 65535);     // two pages at once
    push_req(MODE_RESERVE, 0, 1, 0);            // split one-slot tail
    push_req(MODE_RELEASE, 1, 10, 0);           // plain release
    push_req(MODE_RELEASE, 3, 2, 0);            // overlaps free space
    push_req(MODE_RELEASE, 0, 1, 0);            // merge with next
    push_req(MODE_RELEASE, 12, 1, 0);           // one-slot run
    push_req(MODE_RELEASE, 11, 1, 0);           // merge on both sides
    push_req(MODE_RESERVE, 0, 13, 0);           // exact fit after merges
    push_req(MODE_RESERVE, 0, 2, 65535);
    push_req(MODE_RELEASE, 4095, 8191, 65535);
    push_req(MODE_RESERVE, 0, 600, 65535);      // grow using tail run
    wait_idle();

    // long receiver hold while requests keep coming
    long_hold = 400;
    push_random(30);
    wait_idle();

    for (ph = 0; ph < 5; ph++) begin
      write_limit(lims[ph]);
      if (ph == 4) idle_en = 1'b0;
      push_random(160);
      wait_idle();
    end

    $display("covered %0d requests: %0d with growth, %0d reserve failures",
             n_done, n_grow, n_fail);
    $display("limit settings 0, 1500, 2049, 4096 and 8191, final committed end %0d",
             commit_end);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hdl/csa_pkg.sv
hdl/csa_store.sv
hdl/contiguous_slot_allocator.sv
dv/contiguous_slot_allocator_tb.sv
